// ===== sv/dnle_pkg.sv =====
// shared types and constants for the dns name label encoder
// no dependencies

package dnle_pkg;

  localparam int CNT_W   = 6;
  localparam int RAM_AW  = CNT_W + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  localparam logic [CNT_W-1:0] LABEL_MAX = 6'd62;
  localparam logic [7:0]       DOT_CHAR  = 8'h2E;

  // one closed label waiting to be emitted
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] len;
    logic             ovf;
    logic             term;
  } cmd_t;

  // label buffer write port
  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  // back end hands a buffer bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

// ===== sv/dnle_ram.sv =====
// generic single write port ram with registered read
// no dependencies

module dnle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/dnle_front.sv =====
// front end: accepts name bytes, buffers label characters, closes labels
// depends on dnle_pkg

module dnle_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tlast,
  input  logic            fifo_full,
  input  dnle_pkg::rel_t  rel,
  output dnle_pkg::wr_t   wr,
  output logic            push,
  output dnle_pkg::cmd_t  cmd
);
  import dnle_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       busy_r, busy_nxt;

  logic             acc, dot, room, store, ovf_now, close;
  logic [CNT_W-1:0] len_now;

  always_comb begin
    dot     = (in_tdata == DOT_CHAR);
    acc     = in_tvalid & in_tready;
    room    = (cnt_r < LABEL_MAX);
    store   = !dot && room;
    ovf_now = ovf_r | (!dot && !room);
    len_now = store ? cnt_r + CNT_W'(1) : cnt_r;
    close   = dot | in_tlast;

    wr.en   = acc & store;
    wr.addr = {bank_r, cnt_r};
    wr.data = in_tdata;

    push     = acc & close;
    cmd.bank = bank_r;
    cmd.len  = len_now;
    cmd.ovf  = ovf_now;
    cmd.term = in_tlast;

    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    bank_nxt = bank_r;
    if (acc) begin
      if (close) begin
        cnt_nxt  = '0;
        bank_nxt = ~bank_r;
        ovf_nxt  = in_tlast ? 1'b0 : ovf_now;
      end else begin
        cnt_nxt = len_now;
        ovf_nxt = ovf_now;
      end
    end

    busy_nxt = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (push) begin
      busy_nxt[bank_r] = 1'b1;
    end
  end

  // a bank in use by the back end may not be overwritten
  assign in_tready = !busy_r[bank_r] && !fifo_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      bank_r <= 1'b0;
      busy_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      bank_r <= bank_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// ===== sv/dnle_cmd_fifo.sv =====
// two entry queue of closed labels between front and back end
// depends on dnle_pkg

module dnle_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dnle_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output dnle_pkg::cmd_t head
);
  import dnle_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  always_comb begin
    do_push    = push && !full;
    do_pop     = pop && valid;
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== sv/dnle_back.sv =====
// back end: emits length byte, buffered characters and terminator
// depends on dnle_pkg

module dnle_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cmd_valid,
  input  dnle_pkg::cmd_t          cmd,
  output logic                    pop,
  output logic [dnle_pkg::RAM_AW-1:0] rd_addr,
  input  logic [7:0]              rd_data,
  output dnle_pkg::rel_t          rel,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [7:0]              out_tdata,
  output logic                    out_tlast,
  output logic                    out_tuser
);
  import dnle_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LEN, S_DATA, S_TERM} state_t;

  state_t           state_r, state_nxt;
  cmd_t             cur_r, cur_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r, ob_nxt;
  logic             ol_r, ol_nxt;
  logic             oe_r, oe_nxt;
  logic             can_load;

  always_comb begin
    can_load  = !ov_r || out_tready;
    state_nxt = state_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r && !out_tready;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    oe_nxt    = oe_r;
    pop       = 1'b0;
    rel.valid = 1'b0;
    rel.bank  = cur_r.bank;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          pop       = 1'b1;
          cur_nxt   = cmd;
          idx_nxt   = '0;
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        if (can_load) begin
          ov_nxt = 1'b1;
          ob_nxt = 8'(cur_r.len);
          ol_nxt = 1'b0;
          oe_nxt = cur_r.ovf;
          if (cur_r.len == '0) begin
            rel.valid = 1'b1;
            state_nxt = cur_r.term ? S_TERM : S_IDLE;
          end else begin
            state_nxt = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (can_load) begin
          ov_nxt  = 1'b1;
          ob_nxt  = rd_data;
          ol_nxt  = 1'b0;
          oe_nxt  = cur_r.ovf;
          idx_nxt = idx_r + CNT_W'(1);
          if (idx_r == cur_r.len - CNT_W'(1)) begin
            rel.valid = 1'b1;
            state_nxt = cur_r.term ? S_TERM : S_IDLE;
          end
        end
      end
      S_TERM: begin
        if (can_load) begin
          ov_nxt    = 1'b1;
          ob_nxt    = '0;
          ol_nxt    = 1'b1;
          oe_nxt    = cur_r.ovf;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // address the entry that will be current after this edge
    rd_addr = {cur_nxt.bank, idx_nxt};
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = ob_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = oe_r;

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    idx_r <= idx_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
    oe_r  <= oe_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

// ===== sv/dns_name_label_encoder.sv =====
// top level of the dns name label encoder
// depends on dnle_pkg, dnle_ram, dnle_front, dnle_cmd_fifo, dnle_back
//
// usage:
//   in channel carries a dotted name, one character per transfer; in_tlast
//   marks the final character. 0x2E separates labels.
//   out channel carries the wire encoding: per label a length byte and its
//   characters, then a zero byte with out_tlast set. out_tuser flags that a
//   label of this name was longer than 62 characters and was truncated.
// timing:
//   ordinary characters are taken one per cycle, while in_tready is high, into
//   a two bank label buffer. a dot or the final character closes the label and queues it.
//   the back end picks up a label from the queue, then emits its length
//   byte and its characters, and a terminator at name end. a closing
//   transfer reaches out_tvalid through the command queue, the back end's
//   length state and its output register.
//   in_tready drops while both buffer banks wait to be emitted.
// reset:
//   synchronous active low; clears label count, error flag and queue.
// stall:
//   out_tready low holds the output register; the buffer fills and then
//   in_tready falls, no transfer is lost.

module dns_name_label_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] name_byte
  input  logic       in_tlast,   // name_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // out_last
  output logic       out_tuser   // label_too_long
);
  import dnle_pkg::*;

  wr_t               wr;
  cmd_t              push_cmd, head;
  rel_t              rel;
  logic              push, pop, full, head_valid;
  logic [RAM_AW-1:0] rd_addr;
  logic [7:0]        rd_data;

  // front end: classifies characters, fills the label buffer
  dnle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .fifo_full (full),
    .rel       (rel),
    .wr        (wr),
    .push      (push),
    .cmd       (push_cmd)
  );

  // label buffer, two banks used in turn, one label per bank
  dnle_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // closed labels awaiting output
  dnle_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .valid    (head_valid),
    .head     (head)
  );

  // back end: serializes labels onto the out channel
  dnle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (head_valid),
    .cmd        (head),
    .pop        (pop),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .rel        (rel),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== test/dns_name_label_encoder_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for dns_name_label_encoder: streams dotted names in
// and checks the label encoded wire bytes that come out
// depends on dnle_pkg and the dns_name_label_encoder rtl

module dns_name_label_encoder_test;
  import dnle_pkg::*;

  localparam int STORE_DEPTH = int'(LABEL_MAX);  // characters kept per label
  localparam int HOLD_CYCLES = 300;              // long receiver hold-off
  localparam int SHOW_ERRORS = 10;

  // one encoded byte as it should leave the block
  typedef struct packed {
    logic [7:0] code;   // length byte, character or zero terminator
    logic       close;  // terminator of the name
    logic       trunc;  // a label of this name was cut
  } wire_byte_t;

  // predicts the wire encoding and matches it against what the block sends
  class label_scoreboard;
    wire_byte_t  pending[$];
    logic [7:0]  chars[STORE_DEPTH];
    int unsigned nchars;
    bit          trunc;
    int unsigned errors;

    function void push_wire(logic [7:0] code, logic close);
      wire_byte_t w;
      w.code  = code;
      w.close = close;
      w.trunc = trunc;
      pending.push_back(w);
    endfunction

    // length byte, then the buffered characters
    function void close_label();
      push_wire(8'(nchars), 1'b0);
      for (int i = 0; i < nchars; i++) push_wire(chars[i], 1'b0);
      nchars = 0;
    endfunction

    function void note_input(logic [7:0] chr, logic end_flag);
      if (chr == DOT_CHAR) begin
        // a trailing dot only closes the label, no extra empty label
        close_label();
      end else begin
        if (nchars < STORE_DEPTH) begin
          chars[nchars] = chr;
          nchars++;
        end else begin
          trunc = 1'b1;  // over the cap: dropped, flag sticks until name end
        end
        if (end_flag) close_label();
      end
      if (end_flag) begin
        push_wire(8'h00, 1'b1);
        nchars = 0;
        trunc  = 1'b0;
      end
    endfunction

    function void fail_note(string msg);
      errors++;
      if (errors <= SHOW_ERRORS) $display("%t mismatch: %s", $realtime, msg);
    endfunction

    function void check_output(logic [7:0] code, logic close, logic cut);
      wire_byte_t want;
      if (pending.size() == 0) begin
        fail_note($sformatf("unexpected transfer byte=%02h last=%0b too_long=%0b",
                            code, close, cut));
        return;
      end
      want = pending.pop_front();
      if (code !== want.code || close !== want.close || cut !== want.trunc)
        fail_note($sformatf("exp byte=%02h last=%0b too_long=%0b, got %02h %0b %0b",
                            want.code, want.close, want.trunc, code, close, cut));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;  // [7:0] name_byte
  logic       in_tlast = 1'b0;   // name_end
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [7:0] out_byte
  logic       out_tlast;         // out_last
  logic       out_tuser;         // label_too_long

  label_scoreboard sb = new();

  int tx_idle_pct = 6;   // sender gap chance per cycle, percent
  int rx_idle_pct = 54;  // receiver stall chance per cycle, percent
  int items_sent  = 0;
  int hold_req    = 0;   // bumped by the stimulus to ask for a long hold-off
  int hold_served = 0;
  int hold_left   = 0;

  dns_name_label_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_output(out_tdata, out_tlast, out_tuser);
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req != hold_served) begin
      // long hold-off so the label banks fill and the input stalls
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // one character per transfer, with random gaps in front
  task automatic send_item(input logic [7:0] chr, input logic end_flag);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= chr;
    in_tlast  <= end_flag;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(chr, end_flag);
    items_sent++;
  endtask

  // sender pause until every predicted byte has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // mostly short labels, some empty, a few around the cap
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 75) return $urandom_range(1, 6);
    if (r < 97) return $urandom_range(7, 16);
    return $urandom_range(60, 66);
  endfunction

  // well formed name; negative lengths are picked at random
  task automatic send_name(input int first_len, input int last_len);
    logic [8:0] seq[$];
    logic [7:0] chr;
    int nlab, len;
    nlab = $urandom_range(1, 4);
    if (first_len >= 0 && last_len >= 0 && nlab < 2) nlab = 2;
    for (int l = 0; l < nlab; l++) begin
      if (l == 0 && first_len >= 0) len = first_len;
      else if (l == nlab - 1 && last_len >= 0) len = last_len;
      else len = pick_len();
      if (l != 0) seq.push_back({1'b0, DOT_CHAR});
      for (int i = 0; i < len; i++) begin
        do chr = 8'($urandom_range(255)); while (chr == DOT_CHAR);
        seq.push_back({1'b0, chr});
      end
    end
    // trailing dot now and then, and always for an otherwise empty name
    if (seq.size() == 0 || (last_len < 0 && $urandom_range(4) == 0))
      seq.push_back({1'b0, DOT_CHAR});
    seq[seq.size() - 1][8] = 1'b1;
    foreach (seq[i]) send_item(seq[i][7:0], seq[i][8]);
  endtask

  // raw bytes with dots and end flags in odd places
  task automatic send_noise();
    logic [7:0] chr;
    int n;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      chr = 8'($urandom_range(255));
      if ($urandom_range(3) == 0) chr = DOT_CHAR;
      send_item(chr, (i == n - 1) || ($urandom_range(9) == 0));
    end
  endtask

  task automatic send_random_until(input int goal);
    while (items_sent < goal) begin
      if ($urandom_range(99) < 15) send_noise();
      else send_name(-1, -1);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed names
    send_item(DOT_CHAR, 1'b1);     // root only: zero length, terminator
    send_item(8'h61, 1'b1);        // one character name
    send_item(8'h00, 1'b1);        // zero byte as a character
    send_item(8'hFF, 1'b0);        // trailing dot
    send_item(DOT_CHAR, 1'b1);
    send_item(DOT_CHAR, 1'b0);     // leading empty label
    send_item(8'h61, 1'b1);
    send_item(8'h61, 1'b0);        // empty label in the middle
    send_item(DOT_CHAR, 1'b0);
    send_item(DOT_CHAR, 1'b0);
    send_item(8'h62, 1'b1);
    send_item(8'h78, 1'b0);        // empty label then trailing dot
    send_item(DOT_CHAR, 1'b0);
    send_item(DOT_CHAR, 1'b1);
    send_item(8'h7F, 1'b0);        // bit patterns in one label
    send_item(8'h80, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'hAA, 1'b1);
    wait_drained();

    // sender mostly busy, receiver often stalled
    send_name(STORE_DEPTH + 1, 3);  // cut label, flag sticks on the next one
    send_random_until(100);
    wait_drained();

    tx_idle_pct <= 54;
    rx_idle_pct <= 6;
    send_name(-1, STORE_DEPTH);     // exactly at the cap, no cut
    send_random_until(180);
    wait_drained();

    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    send_name(2, STORE_DEPTH + 2);  // cut on the final character
    hold_req <= hold_req + 1;
    for (int i = 0; i < 6; i++) send_name(3, 4);
    send_random_until(260);

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("dns_name_label_encoder_test: done, clean");
    end else begin
      $display("dns_name_label_encoder_test: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("dns_name_label_encoder_test: done, errors");
    $finish;
  end

endmodule
